### hdl/rufsw_pkg.sv
// shared types and constants for the rollback union-find spanning weight unit
// depends on nothing; used by every module of the block
package rufsw_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int MAX_LOG    = 1024;
    localparam int HIST_DEPTH = MAX_LOG + 1;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int SIZE_W     = $clog2(MAX_NODES) + 1;
    localparam int FILL_W     = $clog2(MAX_LOG + 1);
    localparam int LOG_AW     = $clog2(MAX_LOG);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int EDGE_W     = 10;
    localparam int WEIGHT_W   = 32;
    localparam int EW_W       = 16;
    localparam int OFF_W      = 11;
    localparam int CNT_W      = 11;

    // op codes
    localparam logic [1:0] OP_MERGE = 2'd0;
    localparam logic [1:0] OP_UNDO  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    // unused code, reports the newest entry
    localparam logic [1:0] OP_SPARE = 2'd3;

    // configuration register index
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [SIZE_W-1:0] size;
    } node_entry_t;

    typedef struct packed {
        logic              linked;
        logic [NODE_W-1:0] node;
    } log_entry_t;

    typedef struct packed {
        logic [EDGE_W-1:0]   edges;
        logic [WEIGHT_W-1:0] weight;
    } hist_entry_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        node_entry_t       data;
    } node_wr_t;

    typedef struct packed {
        logic              en;
        logic [LOG_AW-1:0] addr;
        log_entry_t        data;
    } log_wr_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        hist_entry_t        data;
    } hist_wr_t;

endpackage

### hdl/rufsw_node_store.sv
// node memory holding parent and set size per node, with a clearing sweep after reset
// depends on rufsw_pkg
module rufsw_node_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rufsw_pkg::NODE_W-1:0] rd_addr,
    output rufsw_pkg::node_entry_t      rd_data,
    input  rufsw_pkg::node_wr_t         wr,
    output logic                        busy
);
    import rufsw_pkg::*;

    node_entry_t mem [MAX_NODES];
    logic [NODE_W:0] clr_cnt_reg;
    node_entry_t     rd_data_reg;

    assign busy    = (clr_cnt_reg < (NODE_W+1)'(MAX_NODES));
    assign rd_data = rd_data_reg;

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (busy)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // write port: sweep has priority, then requests
    always_ff @(posedge clk)
    begin
        if (busy)
            mem[clr_cnt_reg[NODE_W-1:0]] <= '{parent: clr_cnt_reg[NODE_W-1:0],
                                               size: SIZE_W'(1)};
        else if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

### hdl/rufsw_log_store.sv
// undo log and history memories; history entry zero always reads as zeros
// depends on rufsw_pkg
module rufsw_log_store (
    input  logic                          clk,
    input  logic [rufsw_pkg::LOG_AW-1:0]  log_rd_addr,
    output rufsw_pkg::log_entry_t         log_rd_data,
    input  rufsw_pkg::log_wr_t            log_wr,
    input  logic [rufsw_pkg::HIST_AW-1:0] hist_rd_addr,
    output rufsw_pkg::hist_entry_t        hist_rd_data,
    input  rufsw_pkg::hist_wr_t           hist_wr
);
    import rufsw_pkg::*;

    log_entry_t  log_mem  [MAX_LOG];
    hist_entry_t hist_mem [HIST_DEPTH];
    log_entry_t  log_rd_reg;
    hist_entry_t hist_rd_reg;
    logic        hist_zero_reg;

    // undo log
    always_ff @(posedge clk)
    begin
        if (log_wr.en)
            log_mem[log_wr.addr] <= log_wr.data;
        log_rd_reg <= log_mem[log_rd_addr];
    end

    // history
    always_ff @(posedge clk)
    begin
        if (hist_wr.en)
            hist_mem[hist_wr.addr] <= hist_wr.data;
        hist_rd_reg   <= hist_mem[hist_rd_addr];
        hist_zero_reg <= (hist_rd_addr == '0);
    end

    assign log_rd_data  = log_rd_reg;
    assign hist_rd_data = hist_zero_reg ? '0 : hist_rd_reg;

endmodule

### hdl/rollback_union_find_spanning_weight_unit.sv
// Union-find with undo over 1024 nodes. After reset the node memory is cleared, during
// which no request is taken (configuration writes are). A merge walks each endpoint to
// its root through the single node memory read port, one parent read at a time, and
// links with union by size; undo takes back the newest logged merge if the log holds
// one, and query and the spare op report a history entry. The result sits in an output
// register so the next request can enter while it waits.
module rollback_union_find_spanning_weight_unit (
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = node_a[9:0], node_b[19:10], edge_weight[35:20],
    // back_offset[46:36], zero fill; tuser = op[1:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    // result: tdata = spanning_weight[31:0], forest_edges[41:32], zero fill;
    // tuser = error[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [0:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rufsw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FA_WAIT, ST_FA_CHK, ST_FB_WAIT, ST_FB_CHK, ST_LINK, ST_LINK2,
        ST_U_LOG_WAIT, ST_U_LOG_CHK, ST_U_V_WAIT, ST_U_V_CHK, ST_U_P_WAIT, ST_U_P_CHK,
        ST_U_WRV, ST_RPT_WAIT, ST_RPT
    } st_t;

    st_t                 state_reg;
    logic                finish_reg;
    logic [NODE_W-1:0]   b_reg;
    logic [EW_W-1:0]     w_reg;
    logic [NODE_W-1:0]   cur_reg;
    logic [NODE_W-1:0]   ra_reg;
    logic [SIZE_W-1:0]   size_a_reg;
    logic [NODE_W-1:0]   rb_reg;
    logic [SIZE_W-1:0]   size_b_reg;
    logic [NODE_W-1:0]   v_reg;
    logic [SIZE_W-1:0]   size_v_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [LOG_AW-1:0]   log_addr_reg;
    logic [HIST_AW-1:0]  hist_addr_reg;
    hist_entry_t         res_reg;
    logic                res_err_reg;
    logic [CNT_W-1:0]    node_count_reg;
    logic                out_valid_reg;
    logic [47:0]         out_data_reg;
    logic                out_err_reg;
    node_wr_t            node_wr_reg;
    log_wr_t             log_wr_reg;
    hist_wr_t            hist_wr_reg;

    node_entry_t         node_rd;
    log_entry_t          log_rd;
    hist_entry_t         hist_rd;
    logic                clr_busy;

    logic [1:0]          in_op;
    logic [NODE_W-1:0]   in_a;
    logic [NODE_W-1:0]   in_b;
    logic [OFF_W-1:0]    in_off;
    logic                accept;
    logic                out_free;
    logic                swap;
    logic [NODE_W-1:0]   big;
    logic [NODE_W-1:0]   sml;
    logic [SIZE_W-1:0]   size_big;
    logic [SIZE_W-1:0]   size_sml;
    logic                spans;
    logic [FILL_W-1:0]   fill_dec;
    logic                cfg_wr;

    rufsw_node_store u_node (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (cur_reg),
        .rd_data (node_rd),
        .wr      (node_wr_reg),
        .busy    (clr_busy)
    );

    rufsw_log_store u_log (
        .clk          (clk),
        .log_rd_addr  (log_addr_reg),
        .log_rd_data  (log_rd),
        .log_wr       (log_wr_reg),
        .hist_rd_addr (hist_addr_reg),
        .hist_rd_data (hist_rd),
        .hist_wr      (hist_wr_reg)
    );

    // request fields
    assign in_op    = s_tuser;
    assign in_a     = s_tdata[9:0];
    assign in_b     = s_tdata[19:10];
    assign in_off   = s_tdata[46:36];
    assign s_tready = (state_reg == ST_IDLE) && !finish_reg && !clr_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // link order by set size
    assign swap     = (size_a_reg < size_b_reg);
    assign big      = swap ? rb_reg : ra_reg;
    assign sml      = swap ? ra_reg : rb_reg;
    assign size_big = swap ? size_b_reg : size_a_reg;
    assign size_sml = swap ? size_a_reg : size_b_reg;
    assign fill_dec = fill_reg - 1'b1;

    // spanning test on the selected entry
    assign spans = (node_count_reg != '0) &&
                   ({1'b0, res_reg.edges} == (node_count_reg - 1'b1));

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            finish_reg    <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            node_wr_reg   <= '0;
            log_wr_reg    <= '0;
            hist_wr_reg   <= '0;
            cur_reg       <= '0;
            log_addr_reg  <= '0;
            hist_addr_reg <= '0;
        end
        else
        begin
            node_wr_reg.en <= 1'b0;
            log_wr_reg.en  <= 1'b0;
            hist_wr_reg.en <= 1'b0;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            // hand finished result to the output register
            if (finish_reg && out_free)
            begin
                finish_reg    <= 1'b0;
                out_valid_reg <= 1'b1;
                out_err_reg   <= res_err_reg;
                out_data_reg  <= {6'd0, res_reg.edges,
                                  (spans && !res_err_reg) ? res_reg.weight : '0};
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        b_reg  <= in_b;
                        w_reg  <= s_tdata[35:20];
                        unique case (in_op)
                            OP_MERGE:
                            begin
                                if (fill_reg == FILL_W'(MAX_LOG))
                                begin
                                    res_reg     <= '0;
                                    res_err_reg <= 1'b1;
                                    finish_reg  <= 1'b1;
                                end
                                else
                                begin
                                    cur_reg       <= in_a;
                                    hist_addr_reg <= HIST_AW'(fill_reg);
                                    state_reg     <= ST_FA_WAIT;
                                end
                            end
                            OP_UNDO:
                            begin
                                if (fill_reg == '0)
                                begin
                                    hist_addr_reg <= '0;
                                    state_reg     <= ST_RPT_WAIT;
                                end
                                else
                                begin
                                    log_addr_reg <= fill_dec[LOG_AW-1:0];
                                    state_reg    <= ST_U_LOG_WAIT;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (in_off > fill_reg)
                                begin
                                    res_reg     <= '0;
                                    res_err_reg <= 1'b1;
                                    finish_reg  <= 1'b1;
                                end
                                else
                                begin
                                    hist_addr_reg <= HIST_AW'(fill_reg - in_off);
                                    state_reg     <= ST_RPT_WAIT;
                                end
                            end
                            default:
                            begin
                                hist_addr_reg <= HIST_AW'(fill_reg);
                                state_reg     <= ST_RPT_WAIT;
                            end
                        endcase
                    end
                end
                // walk endpoint a to its root
                ST_FA_WAIT: state_reg <= ST_FA_CHK;
                ST_FA_CHK:
                begin
                    if (node_rd.parent == cur_reg)
                    begin
                        ra_reg     <= cur_reg;
                        size_a_reg <= node_rd.size;
                        cur_reg    <= b_reg;
                        state_reg  <= ST_FB_WAIT;
                    end
                    else
                    begin
                        cur_reg   <= node_rd.parent;
                        state_reg <= ST_FA_WAIT;
                    end
                end
                // walk endpoint b to its root
                ST_FB_WAIT: state_reg <= ST_FB_CHK;
                ST_FB_CHK:
                begin
                    if (node_rd.parent == cur_reg)
                    begin
                        rb_reg     <= cur_reg;
                        size_b_reg <= node_rd.size;
                        state_reg  <= ST_LINK;
                    end
                    else
                    begin
                        cur_reg   <= node_rd.parent;
                        state_reg <= ST_FB_WAIT;
                    end
                end
                // log, push history and, when the roots differ, grow the larger root
                ST_LINK:
                begin
                    log_wr_reg.en   <= 1'b1;
                    log_wr_reg.addr <= fill_reg[LOG_AW-1:0];
                    hist_wr_reg.en   <= 1'b1;
                    hist_wr_reg.addr <= HIST_AW'(fill_reg + 1'b1);
                    fill_reg         <= fill_reg + 1'b1;
                    res_err_reg      <= 1'b0;
                    if (ra_reg == rb_reg)
                    begin
                        log_wr_reg.data  <= '0;
                        hist_wr_reg.data <= hist_rd;
                        res_reg          <= hist_rd;
                        finish_reg       <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        log_wr_reg.data  <= '{linked: 1'b1, node: sml};
                        hist_wr_reg.data <= '{edges: hist_rd.edges + 1'b1,
                                              weight: hist_rd.weight + WEIGHT_W'(w_reg)};
                        res_reg          <= '{edges: hist_rd.edges + 1'b1,
                                              weight: hist_rd.weight + WEIGHT_W'(w_reg)};
                        node_wr_reg.en   <= 1'b1;
                        node_wr_reg.addr <= big;
                        node_wr_reg.data <= '{parent: big, size: size_big + size_sml};
                        state_reg        <= ST_LINK2;
                    end
                end
                // hang the smaller root below the larger
                ST_LINK2:
                begin
                    node_wr_reg.en   <= 1'b1;
                    node_wr_reg.addr <= sml;
                    node_wr_reg.data <= '{parent: big, size: size_sml};
                    finish_reg       <= 1'b1;
                    state_reg        <= ST_IDLE;
                end
                // undo: read newest log entry
                ST_U_LOG_WAIT: state_reg <= ST_U_LOG_CHK;
                ST_U_LOG_CHK:
                begin
                    if (log_rd.linked)
                    begin
                        cur_reg   <= log_rd.node;
                        v_reg     <= log_rd.node;
                        state_reg <= ST_U_V_WAIT;
                    end
                    else
                    begin
                        fill_reg      <= fill_dec;
                        hist_addr_reg <= HIST_AW'(fill_dec);
                        state_reg     <= ST_RPT_WAIT;
                    end
                end
                ST_U_V_WAIT: state_reg <= ST_U_V_CHK;
                ST_U_V_CHK:
                begin
                    size_v_reg <= node_rd.size;
                    cur_reg    <= node_rd.parent;
                    state_reg  <= ST_U_P_WAIT;
                end
                ST_U_P_WAIT: state_reg <= ST_U_P_CHK;
                // shrink the parent set
                ST_U_P_CHK:
                begin
                    node_wr_reg.en   <= 1'b1;
                    node_wr_reg.addr <= cur_reg;
                    node_wr_reg.data <= '{parent: node_rd.parent,
                                          size: node_rd.size - size_v_reg};
                    state_reg        <= ST_U_WRV;
                end
                // detach the node
                ST_U_WRV:
                begin
                    node_wr_reg.en   <= 1'b1;
                    node_wr_reg.addr <= v_reg;
                    node_wr_reg.data <= '{parent: v_reg, size: size_v_reg};
                    fill_reg         <= fill_dec;
                    hist_addr_reg    <= HIST_AW'(fill_dec);
                    state_reg        <= ST_RPT_WAIT;
                end
                // report a history entry
                ST_RPT_WAIT: state_reg <= ST_RPT;
                ST_RPT:
                begin
                    res_reg     <= hist_rd;
                    res_err_reg <= 1'b0;
                    finish_reg  <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= CNT_W'(MAX_NODES);
        else if (cfg_wr)
            node_count_reg <= pwdata[CNT_W-1:0];
    end

    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {21'd0, node_count_reg} : 32'd0;

endmodule

### dv/rollback_union_find_spanning_weight_unit_tb.sv
// testbench for the rollback union-find spanning weight unit: directed table, then random
// merge/undo/query streams checked against a behavioral union-find with undo
// depends on rufsw_pkg and the rollback_union_find_spanning_weight_unit rtl
module rollback_union_find_spanning_weight_unit_tb;
    import rufsw_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  op;
        logic [9:0]  na;
        logic [9:0]  nb;
        logic [15:0] w;
        logic [10:0] off;
        bit          fixed;
        logic [31:0] x_weight;
        logic [9:0]  x_edges;
        logic        x_err;
    } stim_row_t;

    typedef struct {
        logic [31:0] weight;
        logic [9:0]  edges;
        logic        err;
    } span_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [9:0]  uf_parent [MAX_NODES];
    logic [10:0] uf_size [MAX_NODES];
    logic        undo_linked [MAX_LOG];
    logic [9:0]  undo_node [MAX_LOG];
    logic [9:0]  hist_edges [MAX_LOG+1];
    logic [31:0] hist_weight [MAX_LOG+1];
    int          fill;
    logic [10:0] nodes_in_use;

    span_result_t pending_results[$];
    int  fail_count;
    int  mismatch_count;
    int  result_count;
    int  cycle_count;
    int  items_sent;
    bit  hold_off;

    rollback_union_find_spanning_weight_unit dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [9:0] root_of(input logic [9:0] x);
        int steps;
        for (steps = 0; steps < MAX_NODES && uf_parent[x] != x; steps++)
            x = uf_parent[x];
        return x;
    endfunction

    function automatic span_result_t entry_result(input int idx, input logic err);
        span_result_t r;
        r.err = err;
        r.weight = '0;
        r.edges = '0;
        if (!err)
        begin
            r.edges = hist_edges[idx];
            if (nodes_in_use != 0 && {1'b0, hist_edges[idx]} == nodes_in_use - 11'd1)
                r.weight = hist_weight[idx];
        end
        return r;
    endfunction

    task automatic reset_forest();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            uf_parent[i] = i;
            uf_size[i] = 1;
        end
        hist_edges[0] = '0;
        hist_weight[0] = '0;
        fill = 0;
        nodes_in_use = 11'd1024;
    endtask

    // applies one request to the forest and returns the report
    function automatic span_result_t apply_request(input logic [1:0] op, input logic [9:0] na,
                                                   input logic [9:0] nb, input logic [15:0] w,
                                                   input logic [10:0] off);
        logic [9:0] ra;
        logic [9:0] rb;
        logic [9:0] t;
        logic [9:0] v;
        if (op == OP_MERGE)
        begin
            if (fill >= MAX_LOG)
                return entry_result(0, 1'b1);
            ra = root_of(na);
            rb = root_of(nb);
            hist_edges[fill+1] = hist_edges[fill];
            hist_weight[fill+1] = hist_weight[fill];
            if (ra == rb)
            begin
                undo_linked[fill] = 1'b0;
                undo_node[fill] = '0;
            end
            else
            begin
                if (uf_size[ra] < uf_size[rb])
                begin
                    t = ra;
                    ra = rb;
                    rb = t;
                end
                uf_size[ra] = uf_size[ra] + uf_size[rb];
                uf_parent[rb] = ra;
                undo_linked[fill] = 1'b1;
                undo_node[fill] = rb;
                hist_edges[fill+1] = hist_edges[fill] + 10'd1;
                hist_weight[fill+1] = hist_weight[fill] + w;
            end
            fill++;
            return entry_result(fill, 1'b0);
        end
        if (op == OP_UNDO)
        begin
            if (fill > 0)
            begin
                if (undo_linked[fill-1])
                begin
                    v = undo_node[fill-1];
                    uf_size[uf_parent[v]] = uf_size[uf_parent[v]] - uf_size[v];
                    uf_parent[v] = v;
                end
                fill--;
            end
            return entry_result(fill, 1'b0);
        end
        if (op == OP_QUERY)
        begin
            if (off > fill)
                return entry_result(0, 1'b1);
            return entry_result(fill - off, 1'b0);
        end
        return entry_result(fill, 1'b0);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        span_result_t x;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                x = pending_results.pop_front();
                if (m_tdata[31:0] !== x.weight || m_tdata[41:32] !== x.edges
                    || m_tdata[47:42] !== 6'd0 || m_tuser[0] !== x.err)
                begin
                    fail_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: expected w=%0d e=%0d err=%0d got w=%0d e=%0d err=%0d",
                                 x.weight, x.edges, x.err, m_tdata[31:0], m_tdata[41:32],
                                 m_tuser[0]);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic write_node_count(input logic [10:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_NODE_COUNT, 2'b00};
        pwdata <= {21'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        nodes_in_use = value;
    endtask

    // sends one request with a random gap in front
    task automatic send_request(input logic [1:0] op, input logic [9:0] na,
                                input logic [9:0] nb, input logic [15:0] w,
                                input logic [10:0] off, input bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, off, w, nb, na};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(apply_request(op, na, nb, w, off));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic random_phase(input int count, input int span);
        int r;
        logic [1:0] op;
        logic [9:0] na;
        logic [9:0] nb;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 60) ? OP_MERGE : (r < 80) ? OP_UNDO : (r < 97) ? OP_QUERY : OP_SPARE;
            na = (span >= 1024 || $urandom_range(0, 9) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(0, span - 1));
            nb = (span >= 1024 || $urandom_range(0, 9) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(0, span - 1));
            send_request(op, na, nb, 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                     : 11'($urandom_range(0, fill + 1)), 1'b0);
        end
    endtask

    // stimulus
    initial
    begin
        stim_row_t dir_rows[$];
        stim_row_t row;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        fail_count = 0;
        mismatch_count = 0;
        result_count = 0;
        items_sent = 0;
        hold_off = 1'b0;
        reset_forest();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // four nodes in use during the directed part
        write_node_count(11'd4);

        // op, a, b, weight, offset, fixed, expected weight, edges, error
        dir_rows = '{
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    1, 32'd0, 10'd0, 1'b0},
            '{OP_QUERY, 10'd0,    10'd0,    16'd0,     11'd0,    1, 32'd0, 10'd0, 1'b0},
            '{OP_QUERY, 10'd0,    10'd0,    16'd0,     11'd1,    1, 32'd0, 10'd0, 1'b1},
            '{OP_QUERY, 10'd0,    10'd0,    16'd0,     11'd2047, 1, 32'd0, 10'd0, 1'b1},
            '{OP_MERGE, 10'd0,    10'd1,    16'd65535, 11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_MERGE, 10'd1,    10'd0,    16'd7,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_MERGE, 10'd2,    10'd3,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_MERGE, 10'd3,    10'd0,    16'd65535, 11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_QUERY, 10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_QUERY, 10'd0,    10'd0,    16'd0,     11'd4,    0, 32'd0, 10'd0, 1'b0},
            '{OP_QUERY, 10'd0,    10'd0,    16'd0,     11'd5,    1, 32'd0, 10'd0, 1'b1},
            '{OP_SPARE, 10'd1023, 10'd1023, 16'hffff,  11'h7ff,  0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_MERGE, 10'd1023, 10'd512,  16'h5555,  11'h555,  0, 32'd0, 10'd0, 1'b0},
            '{OP_MERGE, 10'd341,  10'd682,  16'haaaa,  11'h2aa,  0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    0, 32'd0, 10'd0, 1'b0},
            '{OP_UNDO,  10'd0,    10'd0,    16'd0,     11'd0,    1, 32'd0, 10'd0, 1'b0}
        };
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_request(row.op, row.na, row.nb, row.w, row.off, 1'b0);
            // typed-in expectation takes the place of the predicted one
            if (row.fixed)
                pending_results[pending_results.size() - 1] =
                    '{row.x_weight, row.x_edges, row.x_err};
        end
        wait_drained();

        // small forest that spans often
        write_node_count(11'd8);
        random_phase(80, 8);
        wait_drained();

        // receiver holds off while the sender keeps offering requests
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++)
            send_request(OP_QUERY, 10'd0, 10'd0, 16'd0, 11'($urandom_range(0, 3)), 1'b1);
        wait_drained();

        // node count at its extremes, then at 32 and 1024
        write_node_count(11'd1);
        random_phase(30, 4);
        wait_drained();
        write_node_count(11'd0);
        random_phase(20, 4);
        wait_drained();
        write_node_count(11'd2047);
        random_phase(20, 16);
        wait_drained();
        write_node_count(11'd32);
        random_phase(80, 32);
        wait_drained();
        write_node_count(11'd1024);
        random_phase(60, 1024);
        wait_drained();

        // fill the log to its limit, merge into the full log, then a random phase
        write_node_count(11'd1024);
        while (fill < MAX_LOG)
            send_request(OP_MERGE, 10'(fill), 10'(fill + 1), 16'hffff, 11'd0, 1'b1);
        send_request(OP_MERGE, 10'd5, 10'd6, 16'd1, 11'd0, 1'b0);
        send_request(OP_QUERY, 10'd0, 10'd0, 16'd0, 11'd1024, 1'b0);
        send_request(OP_QUERY, 10'd0, 10'd0, 16'd0, 11'd1025, 1'b0);
        random_phase(30, 1024);
        wait_drained();

        $display("ran %0d requests (%0d results) over node counts 0 to 2047,", items_sent,
                 result_count);
        $display("incl. full-log merges, empty undo, bad offsets and output backpressure");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
